>>> design/banked_interrupt_controller_top_assert.svh
// Assertion macros used by the checker file of the banked interrupt controller.
// No dependencies; included by bare file name.
`ifndef BANKED_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH
`define BANKED_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define BIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bic checker: same-cycle property failed");

// Next-cycle implication, sampled on aclk, off during reset
`define BIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bic checker: next-cycle property failed");

`endif

>>> design/bic_pkg.sv
// Package for the banked interrupt controller: commands, register offsets,
// bank bases, shared structs and a lowest-set-bit function. No dependencies.
package bic_pkg;

    // Bus commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;

    // Register byte offsets
    localparam logic [5:0] OFF_PEND0 = 6'h00;
    localparam logic [5:0] OFF_PEND1 = 6'h04;
    localparam logic [5:0] OFF_PEND2 = 6'h08;
    localparam logic [5:0] OFF_FIQ   = 6'h0c;
    localparam logic [5:0] OFF_EN1   = 6'h10;
    localparam logic [5:0] OFF_EN2   = 6'h14;
    localparam logic [5:0] OFF_EN0   = 6'h18;
    localparam logic [5:0] OFF_DIS1  = 6'h1c;
    localparam logic [5:0] OFF_DIS2  = 6'h20;
    localparam logic [5:0] OFF_DIS0  = 6'h24;

    // Bank bases for the source number
    localparam logic [6:0] BANK1_BASE = 7'd32;
    localparam logic [6:0] BANK2_BASE = 7'd64;

    // Mask and control state
    typedef struct packed {
        logic [7:0]  base_enable;
        logic [31:0] bank1_enable;
        logic [31:0] bank2_enable;
        logic [7:0]  fiq_control;
    } regs_t;

    // One result beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        next_valid;
        logic [6:0]  next_source;
    } result_t;

    // Index of the lowest set bit, 0 when none (scan is independent per bit)
    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> design/bic_regs.sv
// Enable, disable and FIQ control register file of the banked interrupt controller.
// Depends on bic_pkg. Presents the post-write view in the same cycle.
module bic_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            commit,
    input  logic [1:0]      command,
    input  logic [5:0]      reg_offset,
    input  logic [31:0]     write_data,
    output bic_pkg::regs_t  regs_next
);
    import bic_pkg::*;

    regs_t regs_reg;

    // Write decode: ones set on enable, clear on disable; FIQ control is written whole
    always_comb begin
        regs_next = regs_reg;
        if (command == CMD_WRITE) begin
            unique case (reg_offset)
                OFF_FIQ:  regs_next.fiq_control  = write_data[7:0];
                OFF_EN0:  regs_next.base_enable  = regs_reg.base_enable | write_data[7:0];
                OFF_EN1:  regs_next.bank1_enable = regs_reg.bank1_enable | write_data;
                OFF_EN2:  regs_next.bank2_enable = regs_reg.bank2_enable | write_data;
                OFF_DIS0: regs_next.base_enable  = regs_reg.base_enable & ~write_data[7:0];
                OFF_DIS1: regs_next.bank1_enable = regs_reg.bank1_enable & ~write_data;
                OFF_DIS2: regs_next.bank2_enable = regs_reg.bank2_enable & ~write_data;
                default:  regs_next = regs_reg;
            endcase
        end
    end

    // State update once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (commit) begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> design/bic_eval.sv
// Pending logic, read mux and priority encoder of the banked interrupt controller.
// Depends on bic_pkg. Purely combinational.
module bic_eval (
    input  bic_pkg::regs_t   regs,
    input  logic [1:0]       command,
    input  logic [5:0]       reg_offset,
    input  logic [7:0]       base_sources,
    input  logic [31:0]      bank1_sources,
    input  logic [31:0]      bank2_sources,
    output bic_pkg::result_t result
);
    import bic_pkg::*;

    logic [7:0]  p0;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [4:0]  sc1;
    logic [5:0]  sc2;
    logic [31:0] word;
    logic [6:0]  sc1_src;
    logic [6:0]  sc2_src;

    assign p0 = base_sources & regs.base_enable;
    assign p1 = bank1_sources & regs.bank1_enable;
    assign p2 = bank2_sources & regs.bank2_enable;

    // Shortcut mirrors
    assign sc1 = {p1[19], p1[18], p1[10], p1[9], p1[7]};
    assign sc2 = {p2[30], p2[25], p2[24], p2[23], p2[22], p2[21]};

    // Base pending word; bits 21-31 read as zero
    assign word = {11'd0, sc2, sc1, |p2, |p1, p0};

    // Shortcut source numbers, lowest shortcut first
    always_comb begin
        priority if (sc1[0]) sc1_src = BANK1_BASE + 7'd7;
        else if (sc1[1])     sc1_src = BANK1_BASE + 7'd9;
        else if (sc1[2])     sc1_src = BANK1_BASE + 7'd10;
        else if (sc1[3])     sc1_src = BANK1_BASE + 7'd18;
        else                 sc1_src = BANK1_BASE + 7'd19;
    end

    always_comb begin
        priority if (sc2[0]) sc2_src = BANK2_BASE + 7'd21;
        else if (sc2[1])     sc2_src = BANK2_BASE + 7'd22;
        else if (sc2[2])     sc2_src = BANK2_BASE + 7'd23;
        else if (sc2[3])     sc2_src = BANK2_BASE + 7'd24;
        else if (sc2[4])     sc2_src = BANK2_BASE + 7'd25;
        else                 sc2_src = BANK2_BASE + 7'd30;
    end

    // Next source: base, bank1 shortcuts, bank2 shortcuts, bank1, bank2
    always_comb begin
        result.next_valid = |word;
        result.irq_line   = |word;
        priority if (|p0) result.next_source = {2'b00, lowest_bit({24'd0, p0})};
        else if (|sc1)    result.next_source = sc1_src;
        else if (|sc2)    result.next_source = sc2_src;
        else if (|p1)     result.next_source = BANK1_BASE + {2'b00, lowest_bit(p1)};
        else if (|p2)     result.next_source = BANK2_BASE + {2'b00, lowest_bit(p2)};
        else              result.next_source = 7'd0;
    end

    // Read mux; enable and disable offsets both show the mask
    always_comb begin
        result.read_data = 32'd0;
        if (command == CMD_READ) begin
            unique case (reg_offset)
                OFF_PEND0:          result.read_data = word;
                OFF_PEND1:          result.read_data = p1;
                OFF_PEND2:          result.read_data = p2;
                OFF_FIQ:            result.read_data = {24'd0, regs.fiq_control};
                OFF_EN0, OFF_DIS0:  result.read_data = {24'd0, regs.base_enable};
                OFF_EN1, OFF_DIS1:  result.read_data = regs.bank1_enable;
                OFF_EN2, OFF_DIS2:  result.read_data = regs.bank2_enable;
                default:            result.read_data = 32'd0;
            endcase
        end
    end

endmodule

>>> design/banked_interrupt_controller_top.sv
// Top level of the banked interrupt controller: input register, register file,
// evaluation logic and output register. Depends on bic_pkg, bic_regs, bic_eval.
//
// One beat in, one beat out. A beat carries the source levels of all three
// banks and an optional register access; its result carries read data, the IRQ
// line and the next source to service. Unless stalled, the block takes one beat
// every clock cycle. The input register captures the beat at the accepting edge
// and the output register captures its result when the stage advances, from
// where the m_ ports show it. A write changes the masks before the beat's
// pending state is formed, so its result already reflects the new masks.
// Stalls on m_ready hold the pipeline; s_ready follows m_ready combinationally.
module banked_interrupt_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_reg_offset,
    input  logic [31:0] s_write_data,
    input  logic [7:0]  s_base_sources,
    input  logic [31:0] s_bank1_sources,
    input  logic [31:0] s_bank2_sources,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_line,
    output logic        m_next_valid,
    output logic [6:0]  m_next_source
);
    import bic_pkg::*;

    logic        stage_valid_reg;
    logic [1:0]  command_reg;
    logic [5:0]  reg_offset_reg;
    logic [31:0] write_data_reg;
    logic [7:0]  base_sources_reg;
    logic [31:0] bank1_sources_reg;
    logic [31:0] bank2_sources_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    regs_t       regs_next;
    logic        out_free;
    logic        advance;

    // Handshake: the stage moves when the output register is empty or drained
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = stage_valid_reg && out_free;
    assign s_ready  = !stage_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            command_reg       <= s_command;
            reg_offset_reg    <= s_reg_offset;
            write_data_reg    <= s_write_data;
            base_sources_reg  <= s_base_sources;
            bank1_sources_reg <= s_bank1_sources;
            bank2_sources_reg <= s_bank2_sources;
        end
    end

    bic_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (advance),
        .command    (command_reg),
        .reg_offset (reg_offset_reg),
        .write_data (write_data_reg),
        .regs_next  (regs_next)
    );

    bic_eval u_eval (
        .regs          (regs_next),
        .command       (command_reg),
        .reg_offset    (reg_offset_reg),
        .base_sources  (base_sources_reg),
        .bank1_sources (bank1_sources_reg),
        .bank2_sources (bank2_sources_reg),
        .result        (result_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_read_data   = result_reg.read_data;
    assign m_irq_line    = result_reg.irq_line;
    assign m_next_valid  = result_reg.next_valid;
    assign m_next_source = result_reg.next_source;

endmodule

>>> design/bic_checker.sv
// Port-level checker for the banked interrupt controller, bound to the top level.
// Depends on banked_interrupt_controller_top_assert.svh.
`include "banked_interrupt_controller_top_assert.svh"

module bic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_line,
    input logic        m_next_valid,
    input logic [6:0]  m_next_source
);

    // A stalled result beat holds its read data and source number
    `BIC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_next_source))

    // IRQ line and next-valid come from the same pending state
    `BIC_ASSERT_NOW(a_irq_match, m_valid, m_irq_line == m_next_valid)

    // No pending source means source number zero, else a number in the three banks
    `BIC_ASSERT_NOW(a_src_range, m_valid, (m_next_valid || m_next_source == 7'd0) && m_next_source < 7'd96)

    // A draining result side never blocks the input
    `BIC_ASSERT_NOW(a_ready_pass, m_ready, s_ready)

    // Nothing comes out in the cycle right after reset
    `BIC_ASSERT_NOW(a_reset_empty, $past(!aresetn), !m_valid)

endmodule

bind banked_interrupt_controller_top bic_checker u_bic_checker (.*);
